// ===== hdl/irr_pkg.sv =====
// irr_pkg: shared types and codes for the integer running reduction block
// used by every module of the block; depends on nothing
package irr_pkg;

    localparam int unsigned ELEM_W = 64;
    localparam int unsigned ACT_W  = 3;

    localparam logic [ACT_W-1:0] ACT_ADD = 3'd0;
    localparam logic [ACT_W-1:0] ACT_AND = 3'd1;
    localparam logic [ACT_W-1:0] ACT_OR  = 3'd2;
    localparam logic [ACT_W-1:0] ACT_XOR = 3'd3;
    localparam logic [ACT_W-1:0] ACT_MAX = 3'd4;
    localparam logic [ACT_W-1:0] ACT_MIN = 3'd5;

    localparam logic [ELEM_W-1:0] SIGN_FLIP = {1'b1, {(ELEM_W-1){1'b0}}};

    typedef enum logic [2:0] {
        OP_ADD,
        OP_AND,
        OP_OR,
        OP_XOR,
        OP_MAX,
        OP_MIN,
        OP_NONE
    } op_t;

    typedef struct packed {
        op_t               op;
        logic              first_req;
        logic              as_signed;
        logic [ELEM_W-1:0] value;
    } cmd_t;

endpackage

// ===== hdl/irr_front.sv =====
// irr_front: decodes the reduce action of each incoming item into a command
// depends on irr_pkg
module irr_front
    import irr_pkg::*;
(
    input  logic [ACT_W-1:0]  action,
    input  logic              start_req,
    input  logic              is_signed,
    input  logic [ELEM_W-1:0] element_value,
    output cmd_t              cmd
);

    op_t op;

    always_comb
    begin
        unique case (action)
            ACT_ADD: op = OP_ADD;
            ACT_AND: op = OP_AND;
            ACT_OR:  op = OP_OR;
            ACT_XOR: op = OP_XOR;
            ACT_MAX: op = OP_MAX;
            ACT_MIN: op = OP_MIN;
            default: op = OP_NONE;
        endcase
    end

    assign cmd.op        = op;
    assign cmd.first_req = start_req;
    assign cmd.as_signed = is_signed;
    assign cmd.value     = element_value;

endmodule

// ===== hdl/irr_queue.sv =====
// irr_queue: short command queue between the decode and execute parts
// depends on irr_pkg
module irr_queue
    import irr_pkg::*;
#(
    parameter int unsigned DEPTH = 2
)
(
    input  logic clk,
    input  logic rst_n,
    input  logic push,
    input  cmd_t push_cmd,
    output logic full,
    input  logic pop,
    output logic not_empty,
    output cmd_t head_cmd
);

    localparam int unsigned PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int unsigned CNT_W = $clog2(DEPTH + 1);
    localparam logic [PTR_W-1:0] LAST_PTR = PTR_W'(DEPTH - 1);
    localparam logic [CNT_W-1:0] FULL_CNT = CNT_W'(DEPTH);

    cmd_t mem [DEPTH];

    logic [PTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0] count_reg, count_next;

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push)
        begin
            wr_ptr_next = (wr_ptr_reg == LAST_PTR) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (pop)
        begin
            rd_ptr_next = (rd_ptr_reg == LAST_PTR) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (push && !pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (pop && !push)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            mem[wr_ptr_reg] <= push_cmd;
        end
    end

    assign full      = (count_reg == FULL_CNT);
    assign not_empty = (count_reg != '0);
    assign head_cmd  = mem[rd_ptr_reg];

endmodule

// ===== hdl/irr_back.sv =====
// irr_back: applies queued commands to the accumulator and holds the result
// depends on irr_pkg
module irr_back
    import irr_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              cmd_valid,
    input  cmd_t              cmd,
    output logic              cmd_pop,
    output logic              result_valid,
    input  logic              result_stall,
    output logic [ELEM_W-1:0] running_result
);

    logic [ELEM_W-1:0] acc_reg, acc_next;
    logic              awaiting_first_reg, awaiting_first_next;
    logic              out_valid_reg, out_valid_next;
    logic [ELEM_W-1:0] out_data_reg, out_data_next;

    logic [ELEM_W-1:0] elem_key, acc_key, op_res;
    logic              elem_below, acc_below, first;

    assign cmd_pop = cmd_valid && (!out_valid_reg || !result_stall);

    // flipping the sign bit turns signed order into unsigned order
    assign elem_key   = cmd.as_signed ? (cmd.value ^ SIGN_FLIP) : cmd.value;
    assign acc_key    = cmd.as_signed ? (acc_reg ^ SIGN_FLIP) : acc_reg;
    assign elem_below = elem_key < acc_key;
    assign acc_below  = acc_key < elem_key;
    assign first      = cmd.first_req || awaiting_first_reg;

    always_comb
    begin
        unique case (cmd.op)
            OP_ADD:  op_res = cmd.value + acc_reg;
            OP_AND:  op_res = cmd.value & acc_reg;
            OP_OR:   op_res = cmd.value | acc_reg;
            OP_XOR:  op_res = cmd.value ^ acc_reg;
            OP_MAX:  op_res = elem_below ? acc_reg : cmd.value;
            OP_MIN:  op_res = acc_below ? acc_reg : cmd.value;
            default: op_res = acc_reg;
        endcase
    end

    always_comb
    begin
        acc_next            = acc_reg;
        awaiting_first_next = awaiting_first_reg;
        out_valid_next      = out_valid_reg && result_stall;
        out_data_next       = out_data_reg;
        if (cmd_pop)
        begin
            out_valid_next = 1'b1;
            if (cmd.op == OP_NONE)
            begin
                out_data_next = acc_reg;
            end
            else
            begin
                acc_next            = first ? cmd.value : op_res;
                awaiting_first_next = 1'b0;
                out_data_next       = first ? cmd.value : op_res;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            acc_reg            <= '0;
            awaiting_first_reg <= 1'b1;
            out_valid_reg      <= 1'b0;
        end
        else
        begin
            acc_reg            <= acc_next;
            awaiting_first_reg <= awaiting_first_next;
            out_valid_reg      <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        out_data_reg <= out_data_next;
    end

    assign result_valid   = out_valid_reg;
    assign running_result = out_data_reg;

endmodule

// ===== hdl/integer_running_reduction_top.sv =====
// integer_running_reduction_top: running add/and/or/xor/max/min over 64-bit items
// depends on irr_pkg, irr_front, irr_queue, irr_back
//
//  channel  | handshake                   | payload
//  item     | item_valid / item_stall     | action, start_req, is_signed, element_value
//  result   | result_valid / result_stall | running_result
//
// one item per cycle sustained while result_stall stays low
// (item written into the queue, then accumulator and output register as it pops)
// the combinational 64-bit add or compare against the accumulator sets the rate
// reset: accumulator zero, next defined item starts a reduction, queue and output empty
// item_stall rises only when the queue is full; result_stall holds the output
module integer_running_reduction_top
    import irr_pkg::*;
#(
    parameter int unsigned QUEUE_DEPTH = 2
)
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              item_valid,
    output logic              item_stall,
    input  logic [ACT_W-1:0]  action,
    input  logic              start_req,
    input  logic              is_signed,
    input  logic [ELEM_W-1:0] element_value,
    output logic              result_valid,
    input  logic              result_stall,
    output logic [ELEM_W-1:0] running_result
);

    cmd_t in_cmd;
    cmd_t head_cmd;
    logic q_full, q_not_empty, q_pop, q_push;

    irr_front u_front
    (
        .action        (action),
        .start_req     (start_req),
        .is_signed     (is_signed),
        .element_value (element_value),
        .cmd           (in_cmd)
    );

    assign item_stall = q_full;
    assign q_push     = item_valid && !q_full;

    irr_queue #(.DEPTH(QUEUE_DEPTH)) u_queue
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (q_push),
        .push_cmd  (in_cmd),
        .full      (q_full),
        .pop       (q_pop),
        .not_empty (q_not_empty),
        .head_cmd  (head_cmd)
    );

    irr_back u_back
    (
        .clk            (clk),
        .rst_n          (rst_n),
        .cmd_valid      (q_not_empty),
        .cmd            (head_cmd),
        .cmd_pop        (q_pop),
        .result_valid   (result_valid),
        .result_stall   (result_stall),
        .running_result (running_result)
    );

endmodule

// ===== hdl/irr_checker.sv =====
// irr_checker: port-level checks on the integer running reduction block
// depends on irr_pkg; bound to integer_running_reduction_top
module irr_checker
    import irr_pkg::*;
(
    input logic              clk,
    input logic              rst_n,
    input logic              item_valid,
    input logic              item_stall,
    input logic [ACT_W-1:0]  action,
    input logic              start_req,
    input logic              is_signed,
    input logic [ELEM_W-1:0] element_value,
    input logic              result_valid,
    input logic              result_stall,
    input logic [ELEM_W-1:0] running_result
);

    logic [7:0] pending_reg, pending_next;
    logic       item_take, result_take;

    assign item_take   = item_valid && !item_stall;
    assign result_take = result_valid && !result_stall;

    always_comb
    begin
        pending_next = pending_reg;
        if (item_take && !result_take)
        begin
            pending_next = pending_reg + 1'b1;
        end
        else if (result_take && !item_take)
        begin
            pending_next = pending_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pending_reg <= '0;
        end
        else
        begin
            pending_reg <= pending_next;
        end
    end

    a_result_held: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && result_stall |=> result_valid && $stable(running_result))
        else $error("result changed while stalled");

    a_no_phantom_result: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid |-> pending_reg != '0)
        else $error("result shown without an item outstanding");

    a_stall_needs_work: assert property (@(posedge clk) disable iff (!rst_n)
        item_stall |-> pending_reg != '0)
        else $error("item stalled with nothing in flight");

    a_result_follows: assert property (@(posedge clk) disable iff (!rst_n)
        pending_reg != '0 && !result_valid |=> result_valid)
        else $error("outstanding item not presented");

    a_item_held: assert property (@(posedge clk) disable iff (!rst_n)
        item_valid && item_stall |=> item_valid
            && $stable({action, start_req, is_signed, element_value}))
        else $error("stalled item changed");

endmodule

bind integer_running_reduction_top irr_checker u_irr_checker (.*);

// ===== tb/tb_integer_running_reduction_top.sv =====
// tb_integer_running_reduction_top: self-checking bench for the running add/and/or/xor/max/min block
// a scoreboard class predicts every running value; plain tasks drive items with bursts and stalls
// depends on irr_pkg and integer_running_reduction_top
`timescale 1ns / 1ps

module tb_integer_running_reduction_top;
    import irr_pkg::*;

    localparam logic [ACT_W-1:0] ACT_RSVD_A = 3'd6;
    localparam logic [ACT_W-1:0] ACT_RSVD_B = 3'd7;
    localparam logic [ELEM_W-1:0] ALL_ONES = {ELEM_W{1'b1}};
    localparam int RANDOM_ITEMS = 1865;
    localparam int HOLDOFF_CYCLES = 80;
    localparam int DRAIN_LIMIT = 5000;
    localparam int TAIL_CYCLES = 8;

    class reduction_scoreboard;
        logic [ELEM_W-1:0] acc;
        bit                awaiting_first;
        logic [ELEM_W-1:0] expected_running[$];
        int                mismatches;

        function new();
            acc = '0;
            awaiting_first = 1'b1;
            mismatches = 0;
        endfunction

        function logic [ELEM_W-1:0] next_running_value(logic [ACT_W-1:0] act, logic sgn,
                                                        logic [ELEM_W-1:0] elem);
            logic elem_lt_acc;
            logic acc_lt_elem;
            elem_lt_acc = sgn ? ($signed(elem) < $signed(acc)) : (elem < acc);
            acc_lt_elem = sgn ? ($signed(acc) < $signed(elem)) : (acc < elem);
            case (act)
                ACT_ADD: return elem + acc;
                ACT_AND: return elem & acc;
                ACT_OR:  return elem | acc;
                ACT_XOR: return elem ^ acc;
                ACT_MAX: return elem_lt_acc ? acc : elem;
                default: return acc_lt_elem ? acc : elem;
            endcase
        endfunction

        function void note_item(logic [ACT_W-1:0] act, logic start, logic sgn,
                                logic [ELEM_W-1:0] elem);
            logic [ELEM_W-1:0] res;
            if (act > ACT_MIN) begin
                // undefined op: report the accumulator, state untouched
                expected_running.push_back(acc);
                return;
            end
            if (start || awaiting_first)
                res = elem;
            else
                res = next_running_value(act, sgn, elem);
            acc = res;
            awaiting_first = 1'b0;
            expected_running.push_back(res);
        endfunction

        function void check_result(logic [ELEM_W-1:0] got);
            logic [ELEM_W-1:0] want;
            if (expected_running.size() == 0) begin
                mismatches++;
                if (mismatches <= 10)
                    $display("mismatch: result %h with no item outstanding", got);
                return;
            end
            want = expected_running.pop_front();
            if (got !== want) begin
                mismatches++;
                if (mismatches <= 10)
                    $display("mismatch: running_result expected %h actual %h", want, got);
            end
        endfunction
    endclass

    logic              clk = 1'b0;
    logic              rst_n = 1'b0;
    logic              item_valid = 1'b0;
    logic              item_stall;
    logic [ACT_W-1:0]  action = ACT_ADD;
    logic              start_req = 1'b0;
    logic              is_signed = 1'b0;
    logic [ELEM_W-1:0] element_value = '0;
    logic              result_valid;
    logic              result_stall = 1'b0;
    logic [ELEM_W-1:0] running_result;

    reduction_scoreboard sb = new();

    int burst_left = 0;
    int holdoff_req = 0;
    int holdoff_left = 0;
    int counted = 0;
    bit drain_timeout = 1'b0;

    integer_running_reduction_top dut (
        .clk            (clk),
        .rst_n          (rst_n),
        .item_valid     (item_valid),
        .item_stall     (item_stall),
        .action         (action),
        .start_req      (start_req),
        .is_signed      (is_signed),
        .element_value  (element_value),
        .result_valid   (result_valid),
        .result_stall   (result_stall),
        .running_result (running_result)
    );

    always #2 clk = ~clk;

    always @(posedge clk)
    begin
        if (rst_n) begin
            if (item_valid && !item_stall)
                sb.note_item(action, start_req, is_signed, element_value);
            if (result_valid && !result_stall)
                sb.check_result(running_result);
        end
    end

    // receiver stall pattern, with a long hold-off on request
    initial
    begin
        int mode;
        int mode_left;
        mode = 0;
        mode_left = 0;
        forever begin
            @(negedge clk);
            if (holdoff_req != 0) begin
                holdoff_req = 0;
                holdoff_left = HOLDOFF_CYCLES;
            end
            if (holdoff_left > 0) begin
                result_stall = 1'b1;
                holdoff_left--;
            end
            else begin
                if (mode_left == 0) begin
                    mode = $urandom_range(0, 3);
                    mode_left = $urandom_range(10, 80);
                end
                mode_left--;
                case (mode)
                    0: result_stall = 1'b0;
                    1: result_stall = ($urandom_range(0, 99) < 30);
                    2: result_stall = ~result_stall;
                    default: result_stall = ($urandom_range(0, 99) < 75);
                endcase
            end
        end
    end

    task automatic send_item(input logic [ACT_W-1:0] act, input logic start, input logic sgn,
                             input logic [ELEM_W-1:0] elem);
        int gap;
        @(negedge clk);
        if (burst_left == 0 && holdoff_req == 0 && holdoff_left == 0) begin
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
            burst_left = ($urandom_range(0, 5) == 0) ? $urandom_range(30, 60)
                                                     : $urandom_range(1, 24);
            if (gap > 0) begin
                item_valid = 1'b0;
                repeat (gap) @(negedge clk);
            end
        end
        if (burst_left > 0)
            burst_left--;
        action = act;
        start_req = start;
        is_signed = sgn;
        element_value = elem;
        item_valid = 1'b1;
        forever begin
            @(posedge clk);
            if (item_valid && !item_stall)
                break;
        end
    endtask

    task automatic wait_for_results();
        int waited;
        @(negedge clk);
        item_valid = 1'b0;
        waited = 0;
        while (sb.expected_running.size() != 0 && waited < DRAIN_LIMIT) begin
            @(negedge clk);
            waited++;
        end
        if (sb.expected_running.size() != 0)
            drain_timeout = 1'b1;
    endtask

    function automatic logic [ELEM_W-1:0] pick_value();
        case ($urandom_range(0, 6))
            0: return {$urandom, $urandom};
            1: return {$urandom, $urandom};
            2: return ELEM_W'($urandom_range(0, 15));
            3: return -ELEM_W'($urandom_range(1, 16));
            4:
            begin
                case ($urandom_range(0, 3))
                    0: return '0;
                    1: return ALL_ONES;
                    2: return SIGN_FLIP;
                    default: return ~SIGN_FLIP;
                endcase
            end
            5: return {$urandom_range(0, 1) ? ALL_ONES[31:0] : 32'h0, $urandom};
            default: return SIGN_FLIP ^ ELEM_W'($urandom_range(0, 255));
        endcase
    endfunction

    function automatic logic [ACT_W-1:0] pick_op();
        return ACT_W'($urandom_range(ACT_ADD, ACT_MIN));
    endfunction

    initial
    begin
        logic [ACT_W-1:0] op;
        logic             sgn;
        int               len;
        bit               held;
        bit               paused;

        repeat (11) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // directed: undefined op before any reduction, wrap, signed against unsigned order
        send_item(ACT_RSVD_A, 1'b0, 1'b0, 64'hDEAD_BEEF_0123_4567);
        send_item(ACT_ADD, 1'b0, 1'b0, ALL_ONES);
        send_item(ACT_ADD, 1'b0, 1'b0, 64'd1);
        send_item(ACT_OR,  1'b0, 1'b0, 64'h5555_5555_5555_5555);
        send_item(ACT_AND, 1'b0, 1'b0, ALL_ONES);
        send_item(ACT_XOR, 1'b0, 1'b1, ALL_ONES);
        send_item(ACT_MAX, 1'b0, 1'b1, SIGN_FLIP);
        send_item(ACT_MAX, 1'b0, 1'b0, SIGN_FLIP);
        send_item(ACT_MAX, 1'b1, 1'b1, ~SIGN_FLIP);
        send_item(ACT_MAX, 1'b0, 1'b1, SIGN_FLIP);
        send_item(ACT_MAX, 1'b0, 1'b0, SIGN_FLIP);
        send_item(ACT_MIN, 1'b0, 1'b1, ~SIGN_FLIP);
        send_item(ACT_MIN, 1'b0, 1'b0, ~SIGN_FLIP);
        send_item(ACT_MIN, 1'b0, 1'b0, '0);
        send_item(ACT_RSVD_B, 1'b1, 1'b1, ALL_ONES);
        send_item(ACT_AND, 1'b1, 1'b0, '0);
        send_item(ACT_MIN, 1'b1, 1'b1, ALL_ONES);
        send_item(ACT_MIN, 1'b0, 1'b1, '0);
        send_item(ACT_MAX, 1'b0, 1'b1, '0);
        send_item(ACT_XOR, 1'b1, 1'b0, ALL_ONES);
        send_item(ACT_ADD, 1'b0, 1'b1, ALL_ONES);
        send_item(ACT_ADD, 1'b1, 1'b0, SIGN_FLIP);
        send_item(ACT_ADD, 1'b0, 1'b0, SIGN_FLIP);

        held = 1'b0;
        paused = 1'b0;
        while (counted < RANDOM_ITEMS) begin
            op = pick_op();
            sgn = 1'($urandom_range(0, 1));
            len = $urandom_range(1, 12);
            for (int i = 0; i < len; i++) begin
                if (!held && counted >= 600) begin
                    held = 1'b1;
                    holdoff_req = 1;
                end
                if (!paused && counted >= 1300) begin
                    paused = 1'b1;
                    wait_for_results();
                end
                if ($urandom_range(0, 29) == 0)
                    send_item($urandom_range(0, 1) ? ACT_RSVD_A : ACT_RSVD_B,
                              1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)),
                              pick_value());
                send_item(($urandom_range(0, 9) == 0) ? pick_op() : op,
                          (i == 0) ? ($urandom_range(0, 9) != 0) : ($urandom_range(0, 19) == 0),
                          ($urandom_range(0, 15) == 0) ? ~sgn : sgn,
                          pick_value());
                counted++;
            end
        end

        wait_for_results();
        repeat (TAIL_CYCLES) @(posedge clk);

        if (sb.mismatches == 0 && sb.expected_running.size() == 0 && !drain_timeout)
            $display("integer_running_reduction_top verification clean");
        else
            $display("integer_running_reduction_top verification failed");
        $finish;
    end

    initial
    begin
        #2_000_000;
        $display("integer_running_reduction_top verification failed");
        $finish;
    end

endmodule
